// ===== rtl/etcp_pkg.sv =====
// shared types and constants of the eeprom transfer chunk planner
`default_nettype none

package etcp_pkg;

    localparam int ADDR_W   = 17;
    localparam int LEN_W    = 9;
    localparam int DEV_W    = 7;
    localparam int OFFS_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int BUF_W    = 8;
    localparam int PLOG_W   = 3;
    localparam int LIMIT_W  = 8;
    localparam int OP_W     = 2;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 8;

    localparam logic [OP_W-1:0] OP_BLOCK_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ        = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE        = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PAGE_SIZE_LOG2 = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CHUNK_LIMIT    = 2'd2;

    localparam logic [LEN_W-1:0]   MAX_LENGTH   = 9'd256;
    localparam logic [LIMIT_W-1:0] CHUNK_MIN    = 8'd16;
    localparam logic [LIMIT_W-1:0] CHUNK_MAX    = 8'd128;
    localparam logic [PLOG_W-1:0]  PLOG_MIN     = 3'd3;
    localparam logic [DEV_W-1:0]   BANK_SELECT  = 7'h04;
    localparam logic [ADDR_W-1:0]  BANK_BORDER  = 17'h10000;

    localparam logic [DEV_W-1:0]   RST_DEVICE_ADDRESS = 7'd80;
    localparam logic [PLOG_W-1:0]  RST_PAGE_SIZE_LOG2 = 3'd7;
    localparam logic [LIMIT_W-1:0] RST_CHUNK_LIMIT    = 8'd30;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctl_cmd;

    typedef struct packed {
        logic last_chunk;
    } t_dp_status;

    typedef struct packed {
        logic                en;
        logic [CIDX_W-1:0]   index;
        logic [CDATA_W-1:0]  data;
    } t_cfg_wr;

endpackage

`default_nettype wire

// ===== rtl/etcp_if.sv =====
// channel interfaces: request, descriptor and configuration write
`default_nettype none

interface etcp_req_if;
    logic                          valid;
    logic                          ready;
    logic [etcp_pkg::OP_W-1:0]     opcode;
    logic [etcp_pkg::ADDR_W-1:0]   start_address;
    logic [etcp_pkg::LEN_W-1:0]    length;

    modport source (output valid, output opcode, output start_address, output length,
                    input ready);
    modport sink   (input valid, input opcode, input start_address, input length,
                    output ready);
endinterface

interface etcp_desc_if;
    logic                          valid;
    logic                          ready;
    logic                          is_read;
    logic [etcp_pkg::DEV_W-1:0]    device_select;
    logic [etcp_pkg::OFFS_W-1:0]   mem_offset;
    logic [etcp_pkg::COUNT_W-1:0]  byte_count;
    logic [etcp_pkg::BUF_W-1:0]    buffer_offset;
    logic                          last;

    modport source (output valid, output is_read, output device_select, output mem_offset,
                    output byte_count, output buffer_offset, output last, input ready);
    modport sink   (input valid, input is_read, input device_select, input mem_offset,
                    input byte_count, input buffer_offset, input last, output ready);
endinterface

interface etcp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [etcp_pkg::CIDX_W-1:0]   index;
    logic [etcp_pkg::CDATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/etcp_dp.sv =====
// datapath: configuration registers, chunk address and length counters, descriptor register
`default_nettype none

module etcp_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  etcp_pkg::t_cfg_wr              i_cfg_wr,
    input  etcp_pkg::t_ctl_cmd             i_cmd,
    input  wire [etcp_pkg::OP_W-1:0]       i_opcode,
    input  wire [etcp_pkg::ADDR_W-1:0]     i_start_address,
    input  wire [etcp_pkg::LEN_W-1:0]      i_length,
    output etcp_pkg::t_dp_status           o_status,
    output logic                           o_is_read,
    output logic [etcp_pkg::DEV_W-1:0]     o_device_select,
    output logic [etcp_pkg::OFFS_W-1:0]    o_mem_offset,
    output logic [etcp_pkg::COUNT_W-1:0]   o_byte_count,
    output logic [etcp_pkg::BUF_W-1:0]     o_buffer_offset,
    output logic                           o_last
);

    logic [etcp_pkg::DEV_W-1:0]    r_cfg_dev;
    logic [etcp_pkg::PLOG_W-1:0]   r_cfg_plog;
    logic [etcp_pkg::LIMIT_W-1:0]  r_cfg_limit;

    logic [etcp_pkg::ADDR_W-1:0]   r_addr;
    logic [etcp_pkg::LEN_W-1:0]    r_len;
    logic [etcp_pkg::BUF_W-1:0]    r_buf;
    logic                          r_is_read;
    logic                          r_advance;
    logic [etcp_pkg::DEV_W-1:0]    r_dev;
    logic [etcp_pkg::PLOG_W-1:0]   r_plog;
    logic [etcp_pkg::LIMIT_W-1:0]  r_limit;

    logic [etcp_pkg::LIMIT_W-1:0]  limit_eff;
    logic [etcp_pkg::PLOG_W-1:0]   plog_eff;
    logic [etcp_pkg::LEN_W-1:0]    len_sat;
    logic [etcp_pkg::COUNT_W-1:0]  page;
    logic [etcp_pkg::COUNT_W-1:0]  room_w;
    logic [etcp_pkg::ADDR_W-1:0]   room;
    logic [etcp_pkg::COUNT_W-1:0]  cnt_lim;
    logic [etcp_pkg::COUNT_W-1:0]  cnt;
    logic [etcp_pkg::DEV_W-1:0]    sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dev   <= etcp_pkg::RST_DEVICE_ADDRESS;
            r_cfg_plog  <= etcp_pkg::RST_PAGE_SIZE_LOG2;
            r_cfg_limit <= etcp_pkg::RST_CHUNK_LIMIT;
        end else if (i_cfg_wr.en) begin
            case (i_cfg_wr.index)
                etcp_pkg::CFG_DEVICE_ADDRESS: r_cfg_dev   <= i_cfg_wr.data[etcp_pkg::DEV_W-1:0];
                etcp_pkg::CFG_PAGE_SIZE_LOG2: r_cfg_plog  <= i_cfg_wr.data[etcp_pkg::PLOG_W-1:0];
                etcp_pkg::CFG_CHUNK_LIMIT:    r_cfg_limit <= i_cfg_wr.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_limit < etcp_pkg::CHUNK_MIN) begin
            limit_eff = etcp_pkg::CHUNK_MIN;
        end else if (r_cfg_limit > etcp_pkg::CHUNK_MAX) begin
            limit_eff = etcp_pkg::CHUNK_MAX;
        end else begin
            limit_eff = r_cfg_limit;
        end
        plog_eff = (r_cfg_plog < etcp_pkg::PLOG_MIN) ? etcp_pkg::PLOG_MIN : r_cfg_plog;
        len_sat  = (i_length > etcp_pkg::MAX_LENGTH) ? etcp_pkg::MAX_LENGTH : i_length;
    end

    always_comb begin
        page    = 8'd1 << r_plog;
        room_w  = page - (r_addr[etcp_pkg::COUNT_W-1:0] & (page - 8'd1));
        if (r_is_read) begin
            room = etcp_pkg::BANK_BORDER - {1'b0, r_addr[etcp_pkg::OFFS_W-1:0]};
        end else begin
            room = {{(etcp_pkg::ADDR_W-etcp_pkg::COUNT_W){1'b0}}, room_w};
        end
        cnt_lim = (r_len < {1'b0, r_limit}) ? r_len[etcp_pkg::COUNT_W-1:0] : r_limit;
        cnt     = (room < {{(etcp_pkg::ADDR_W-etcp_pkg::COUNT_W){1'b0}}, cnt_lim})
                  ? room[etcp_pkg::COUNT_W-1:0] : cnt_lim;
        sel     = r_addr[etcp_pkg::ADDR_W-1] ? (r_dev | etcp_pkg::BANK_SELECT) : r_dev;
        o_status.last_chunk = (r_len == {1'b0, cnt});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr    <= i_start_address;
            r_len     <= len_sat;
            r_buf     <= '0;
            r_is_read <= (i_opcode == etcp_pkg::OP_READ);
            r_advance <= (i_opcode != etcp_pkg::OP_FILL_WRITE);
            r_dev     <= r_cfg_dev;
            r_plog    <= plog_eff;
            r_limit   <= limit_eff;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + {{(etcp_pkg::ADDR_W-etcp_pkg::COUNT_W){1'b0}}, cnt};
            r_len  <= r_len - {1'b0, cnt};
            r_buf  <= r_buf + cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_is_read       <= r_is_read;
            o_device_select <= sel;
            o_mem_offset    <= r_addr[etcp_pkg::OFFS_W-1:0];
            o_byte_count    <= cnt;
            o_buffer_offset <= r_advance ? r_buf : '0;
            o_last          <= o_status.last_chunk;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/etcp_ctl.sv =====
// controller: request acceptance, chunk sequencing and descriptor valid
`default_nettype none

module etcp_ctl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_req_valid,
    input  wire [etcp_pkg::OP_W-1:0]    i_req_opcode,
    input  wire [etcp_pkg::LEN_W-1:0]   i_req_length,
    input  wire                         i_desc_ready,
    input  etcp_pkg::t_dp_status        i_status,
    output logic                        o_req_ready,
    output logic                        o_desc_valid,
    output logic                        o_busy,
    output etcp_pkg::t_ctl_cmd          o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_desc_valid;
    logic   n_desc_valid;
    logic   req_fire;
    logic   can_step;

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_desc_valid = r_desc_valid;
    assign o_busy       = (r_state == S_RUN);
    assign req_fire     = i_req_valid && o_req_ready;
    assign can_step     = !r_desc_valid || i_desc_ready;

    always_comb begin
        n_state      = r_state;
        n_desc_valid = r_desc_valid && !i_desc_ready;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_fire && i_req_opcode != etcp_pkg::OP_NONE && i_req_length != '0) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (can_step) begin
                    o_cmd.step   = 1'b1;
                    n_desc_valid = 1'b1;
                    if (i_status.last_chunk) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_desc_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_desc_valid <= n_desc_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/eeprom_transfer_chunk_planner.sv =====
// top level of the eeprom transfer chunk planner
//
// usage: a request item (opcode, start_address, length) enters on i_req and is split
// into bus transactions; one descriptor item per transaction leaves on o_desc in
// address order, the final one with last set. writes are cut at the page size and the
// chunk limit, reads at every 64K border and the chunk limit. a fill write keeps
// buffer_offset at 0. opcode three or a length of 0 is taken and gives no descriptors.
// i_cfg writes device_address (0), page_size_log2 (1) and chunk_limit (2) whenever it
// is valid; write it only between requests.
// timing: a request is taken only when the chunk sequencer is idle. acceptance loads
// the chunk counters and each step registers the next descriptor, then one descriptor
// per cycle while o_desc.ready is high; the next request can enter once the final
// chunk has been stepped. the descriptor register parts the two sides: a new request
// can enter while the last descriptor still waits.
// a stalled receiver holds the sequencer on the current chunk with nothing lost.
// reset: synchronous, clears the sequencer and the descriptor valid and restores the
// register defaults 80, 7 and 30.
`default_nettype none

module eeprom_transfer_chunk_planner (
    input  wire           i_clk,
    input  wire           i_rst_n,
    etcp_req_if.sink      i_req,
    etcp_desc_if.source   o_desc,
    etcp_cfg_if.sink      i_cfg
);

    etcp_pkg::t_ctl_cmd   cmd;
    etcp_pkg::t_dp_status status;
    etcp_pkg::t_cfg_wr    cfg_wr;
    logic                 busy;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    etcp_ctl u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (i_req.opcode),
        .i_req_length (i_req.length),
        .i_desc_ready (o_desc.ready),
        .i_status     (status),
        .o_req_ready  (i_req.ready),
        .o_desc_valid (o_desc.valid),
        .o_busy       (busy),
        .o_cmd        (cmd)
    );

    etcp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (cfg_wr),
        .i_cmd           (cmd),
        .i_opcode        (i_req.opcode),
        .i_start_address (i_req.start_address),
        .i_length        (i_req.length),
        .o_status        (status),
        .o_is_read       (o_desc.is_read),
        .o_device_select (o_desc.device_select),
        .o_mem_offset    (o_desc.mem_offset),
        .o_byte_count    (o_desc.byte_count),
        .o_buffer_offset (o_desc.buffer_offset),
        .o_last          (o_desc.last)
    );

`ifndef SYNTH
    a_no_req_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_req.ready)
        else $error("request taken while chunks remain");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc.valid |-> (o_desc.byte_count != '0 && o_desc.byte_count <= etcp_pkg::CHUNK_MAX))
        else $error("descriptor byte count out of range");

    a_not_last_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_desc.valid && !o_desc.last) |-> busy)
        else $error("sequencer idle before the final descriptor");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!busy && !cmd.step))
        else $error("load while sequencing");
`endif

endmodule

`default_nettype wire
